// ===== sv/csll_pkg.sv =====
// shared types and constants for the sensor link logger
// no dependencies

package csll_pkg;

   localparam int unsigned LOG_DEPTH_DEFAULT = 4096;
   localparam int unsigned INDEX_WIDTH       = 12;
   localparam int unsigned REQ_DATA_WIDTH    = 24;
   localparam int unsigned RSP_DATA_WIDTH    = 32;
   localparam int unsigned CSR_ADDR_WIDTH    = 3;
   localparam int unsigned CSR_DATA_WIDTH    = 32;

   localparam logic [7:0] GEN_RESET   = 8'hD4;
   localparam logic [7:0] CODE_RESET  = 8'h00;
   localparam logic [7:0] CODE_ACK    = 8'h40;
   localparam logic [7:0] CODE_REPEAT = 8'h60;
   localparam logic [7:0] CODE_MASK   = 8'hE0;

   localparam logic [1:0] KIND_ACK    = 2'b10;
   localparam logic [1:0] KIND_REPEAT = 2'b11;

   localparam logic CSR_REG_GEN = 1'b0;

   typedef enum logic [1:0] {
      MODE_BYTE  = 2'd0,
      MODE_READ  = 2'd1,
      MODE_RESET = 2'd2
   } mode_type;

   typedef struct packed {
      logic       crc3_ok;
      logic       crc11_ok;
      logic [7:0] ack_byte;
      logic [7:0] repeat_byte;
      logic [7:0] reset_byte;
   } crc_type;

endpackage

// ===== sv/csll_csr.sv =====
// configuration register block holding the crc generator byte
// depends on csll_pkg

module csll_csr
   import csll_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready,
   output logic [7:0]                gen
);

   logic [7:0] gen_ff;
   logic [7:0] gen_in;
   logic       wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      gen_in = gen_ff;
      if (wr_en && csr_paddr[2] == CSR_REG_GEN) begin
         gen_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff <= GEN_RESET;
      end else begin
         gen_ff <= gen_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_REG_GEN) begin
         csr_prdata = {{(CSR_DATA_WIDTH-8){1'b0}}, gen_ff};
      end
   end

   assign gen = gen_ff;

endmodule

// ===== sv/csll_crc.sv =====
// crc3 and crc11 checks on a received command and the reply bytes
// depends on csll_pkg

module csll_crc
   import csll_pkg::*;
(
   input  logic [7:0] gen,
   input  logic [7:0] held_byte,
   input  logic [7:0] rx_byte,
   output crc_type    crc
);

   function automatic logic [7:0] crc3(input logic [7:0] cmd, input logic [7:0] g);
      logic [7:0] code;
      logic [7:0] work;
      code = cmd & CODE_MASK;
      work = code;
      for (int i = 0; i < 3; i++) begin
         if (work[7]) begin
            work = work ^ g;
         end
         work = {work[6:0], 1'b0};
      end
      return code | {3'b000, work[7:3]};
   endfunction

   function automatic logic [7:0] crc11(input logic [7:0] held, input logic [7:0] cmd,
                                        input logic [7:0] g);
      logic [7:0] code;
      logic [7:0] work;
      code = cmd & CODE_MASK;
      work = held;
      for (int i = 0; i < 11; i++) begin
         if (work[7]) begin
            work = work ^ g;
         end
         work = {work[6:0], 1'b0};
         if (i < 3) begin
            work[0] = code[7-i];
         end
      end
      return code | {3'b000, work[7:3]};
   endfunction

   always_comb begin
      crc.crc3_ok     = (crc3(rx_byte, gen) == rx_byte);
      crc.crc11_ok    = (crc11(held_byte, rx_byte, gen) == rx_byte);
      crc.ack_byte    = crc3(CODE_ACK, gen);
      crc.repeat_byte = crc3(CODE_REPEAT, gen);
      crc.reset_byte  = crc3(CODE_RESET, gen);
   end

endmodule

// ===== sv/csll_log_ram.sv =====
// log store: one write port, one read port with registered data
// depends on csll_pkg

module csll_log_ram
   import csll_pkg::*;
#(
   parameter int unsigned DEPTH = LOG_DEPTH_DEFAULT,
   parameter int unsigned AW    = $clog2(LOG_DEPTH_DEFAULT)
)
(
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [7:0]    wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [7:0]    rdata
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/crc_checked_sensor_link_logger_unit.sv =====
// central side of a crc checked byte link to a sensor, with a byte log
// depends on csll_pkg, csll_csr, csll_crc, csll_log_ram
//
// usage
//   req channel: one word per received byte or host command. tuser carries
//   the mode (byte from sensor, read log entry, reset sensor); tdata carries
//   the received byte and the log index to read.
//   rsp channel: exactly one word per req word, in order: byte to send,
//   crc error flag, log read result and the current entry count.
//   csr port: one register, the crc generator byte, at address 0.
// latency: a req word accepted at one edge gives its rsp word valid from the
//   next cycle; log reads come from the store's registered read port.
// throughput: one word per cycle while rsp is not stalled; the held byte, the
//   write position and the crc checks all resolve in the accepting cycle.
// reset: held byte cleared, nothing held, write position zero, generator
//   0xd4. the log store is not cleared; only entries below the write
//   position can be read.
// stall: while rsp is stalled the output word holds and req is taken only
//   in a cycle where the output word drains.

module crc_checked_sensor_link_logger_unit
   import csll_pkg::*;
#(
   parameter int unsigned LOG_DEPTH = LOG_DEPTH_DEFAULT
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // [7:0] rx_byte, [19:8] entry_index, [23:20] zero
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   // [1:0] mode
   input  logic [1:0]                req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [0] send_valid, [8:1] send_byte, [9] crc_error, [10] read_valid,
   // [18:11] read_byte, [30:19] entries_stored, [31] zero
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   localparam int unsigned AW = $clog2(LOG_DEPTH);
   localparam int unsigned CW = (AW > INDEX_WIDTH) ? AW : INDEX_WIDTH;

   logic [7:0]  gen;
   crc_type     crc;
   mode_type    mode;
   logic [7:0]  rx_byte;
   logic [11:0] entry_index;
   logic        acc;

   logic [7:0]    held_byte_ff, held_byte_in;
   logic          held_full_ff, held_full_in;
   logic [AW-1:0] wp_ff, wp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          send_valid_ff, send_valid_in;
   logic [7:0]    send_byte_ff, send_byte_in;
   logic          crc_error_ff, crc_error_in;
   logic          read_valid_ff, read_valid_in;
   logic [11:0]   stored_ff, stored_in;

   logic          log_we;
   logic          log_re;
   logic [7:0]    log_rdata;
   logic [CW-1:0] idx_wide;
   logic [CW-1:0] wp_wide;
   logic [CW-1:0] wp_next_wide;
   logic          cmd_after_data;

   csll_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .gen         (gen)
   );

   csll_crc u_crc (
      .gen       (gen),
      .held_byte (held_byte_ff),
      .rx_byte   (rx_byte),
      .crc       (crc)
   );

   csll_log_ram #(
      .DEPTH (LOG_DEPTH),
      .AW    (AW)
   ) u_log (
      .clock (clock),
      .we    (log_we),
      .waddr (wp_ff),
      .wdata (held_byte_ff),
      .re    (log_re),
      .raddr (idx_wide[AW-1:0]),
      .rdata (log_rdata)
   );

   assign mode        = mode_type'(req_tuser);
   assign rx_byte     = req_tdata[7:0];
   assign entry_index = req_tdata[19:8];
   assign req_tready  = !rsp_valid_ff || rsp_tready;
   assign acc         = req_tvalid && req_tready;

   assign idx_wide       = CW'(entry_index);
   assign wp_wide        = CW'(wp_ff);
   assign cmd_after_data = held_full_ff && held_byte_ff[7];

   always_comb begin
      held_byte_in  = held_byte_ff;
      held_full_in  = held_full_ff;
      wp_in         = wp_ff;
      send_valid_in = 1'b0;
      send_byte_in  = '0;
      crc_error_in  = 1'b0;
      read_valid_in = 1'b0;
      log_we        = 1'b0;
      log_re        = 1'b0;
      if (acc) begin
         unique case (mode)
            MODE_BYTE: begin
               if (rx_byte[7]) begin
                  held_byte_in = rx_byte;
                  held_full_in = 1'b1;
               end else if (cmd_after_data) begin
                  if (crc.crc11_ok) begin
                     log_we        = 1'b1;
                     wp_in         = (wp_ff == AW'(LOG_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
                     held_byte_in  = crc.ack_byte;
                     held_full_in  = 1'b1;
                     send_valid_in = 1'b1;
                     send_byte_in  = crc.ack_byte;
                  end else begin
                     held_full_in  = 1'b0;
                     send_valid_in = 1'b1;
                     send_byte_in  = crc.repeat_byte;
                     crc_error_in  = 1'b1;
                  end
               end else if (!crc.crc3_ok) begin
                  held_full_in  = 1'b0;
                  send_valid_in = 1'b1;
                  send_byte_in  = crc.repeat_byte;
                  crc_error_in  = 1'b1;
               end else if (rx_byte[6:5] == KIND_ACK) begin
                  held_full_in = 1'b0;
               end else if (rx_byte[6:5] == KIND_REPEAT && held_full_ff) begin
                  send_valid_in = 1'b1;
                  send_byte_in  = held_byte_ff;
               end
            end
            MODE_READ: begin
               read_valid_in = (idx_wide < wp_wide);
               log_re        = read_valid_in;
            end
            MODE_RESET: begin
               held_byte_in  = crc.reset_byte;
               held_full_in  = 1'b1;
               send_valid_in = 1'b1;
               send_byte_in  = crc.reset_byte;
            end
            default: begin
            end
         endcase
      end
   end

   assign wp_next_wide = CW'(wp_in);
   assign stored_in    = wp_next_wide[11:0];
   assign rsp_valid_in = acc || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_byte_ff <= '0;
         held_full_ff <= 1'b0;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_byte_ff <= held_byte_in;
         held_full_ff <= held_full_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         send_valid_ff <= send_valid_in;
         send_byte_ff  <= send_byte_in;
         crc_error_ff  <= crc_error_in;
         read_valid_ff <= read_valid_in;
         stored_ff     <= stored_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, stored_ff, (read_valid_ff ? log_rdata : 8'h00),
                        read_valid_ff, crc_error_ff, send_byte_ff, send_valid_ff};

   a_log_write_acks: assert property (@(posedge clock) disable iff (reset)
      log_we |=> rsp_valid_ff && send_valid_ff && !crc_error_ff && held_full_ff)
      else $error("log write not answered by an acknowledge");

   a_error_sends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && crc_error_ff |-> send_valid_ff && !held_full_ff && !read_valid_ff)
      else $error("crc error without repeat request");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      log_re |-> acc && mode == MODE_READ && wp_ff != '0)
      else $error("log read outside written range");

   a_reset_holds: assert property (@(posedge clock) disable iff (reset)
      acc && mode == MODE_RESET |=> held_full_ff && send_valid_ff && $stable(wp_ff))
      else $error("reset mode did not hold reset command");

endmodule
